[rtl/i2c_master_byte_sequencer_unit_assert.svh]
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_unit_assert.svh
// Assertion macros used by the I2C master byte sequencer core.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define I2CMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants of the I2C master byte sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Field widths
  localparam int CYCLE_W     = 16;
  localparam int ACTION_W    = 3;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int TIMER_BITS_DEF = 16;

  // Command codes
  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_PHASE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_PHASE = 2'd1;

  // Reset values of the timing registers
  localparam logic [CYCLE_W-1:0] LOW_PHASE_RESET  = 16'd500;
  localparam logic [CYCLE_W-1:0] HIGH_PHASE_RESET = 16'd400;

  // Byte constants
  localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hff;
  localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

  // One command request
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_read;
    logic                scl_level;
    logic                sda_level;
  } cmd_t;

  // One result request
  typedef struct packed {
    logic              scl_release;
    logic              sda_release;
    logic              busy_res;
    logic              done_res;
    logic              nack_seen;
    logic [BYTE_W-1:0] read_data;
  } res_t;

  // Configuration write request
  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CYCLE_W-1:0]     data;
  } cfg_req_t;

  // Timing registers handed to the sequencer core
  typedef struct packed {
    logic [CYCLE_W-1:0] low_cycles;
    logic [CYCLE_W-1:0] high_cycles;
  } timing_cfg_t;

endpackage

[rtl/i2cms_stream_if.sv]
// ----------------------------------------------------------------------------
// i2cms_stream_if
// Valid/ready channel carrying one payload request per handshake.
// ----------------------------------------------------------------------------
interface i2cms_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

[rtl/i2cms_cfg_regs.sv]
// ----------------------------------------------------------------------------
// i2cms_cfg_regs
// SCL low and high phase count registers, written through the config channel.
// ----------------------------------------------------------------------------
module i2cms_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  i2cms_stream_if.sink          cfg,
  output i2cms_pkg::timing_cfg_t timing
);
  import i2cms_pkg::*;

  timing_cfg_t regs;

  // Always take writes
  assign cfg.ready = 1'b1;
  assign timing    = regs;

  // Update the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_cycles  <= LOW_PHASE_RESET;
      regs.high_cycles <= HIGH_PHASE_RESET;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        REG_LOW_PHASE:  regs.low_cycles  <= cfg.payload.data;
        REG_HIGH_PHASE: regs.high_cycles <= cfg.payload.data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/i2cms_core.sv]
// ----------------------------------------------------------------------------
// i2cms_core
// Bus sequencer state: one accepted tick advances the state by one step and
// yields the result request for that tick.
// ----------------------------------------------------------------------------
module i2cms_core #(
  parameter int TIMER_BITS = i2cms_pkg::TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  i2cms_pkg::cmd_t        cmd,
  input  i2cms_pkg::timing_cfg_t timing,
  output i2cms_pkg::res_t        result
);
  import i2cms_pkg::*;

  `include "i2c_master_byte_sequencer_unit_assert.svh"

  // Phase codes
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_START_WAIT  = 4'd1;
  localparam logic [3:0] PH_START_SETUP = 4'd2;
  localparam logic [3:0] PH_START_HOLD  = 4'd3;
  localparam logic [3:0] PH_BIT_LOW     = 4'd4;
  localparam logic [3:0] PH_BIT_WAIT    = 4'd5;
  localparam logic [3:0] PH_BIT_HIGH    = 4'd6;
  localparam logic [3:0] PH_TAIL        = 4'd7;
  localparam logic [3:0] PH_STOP_WAIT   = 4'd8;
  localparam logic [3:0] PH_STOP_HOLD   = 4'd9;
  localparam logic [3:0] PH_STOP_TAIL   = 4'd10;

  localparam int WideW = (TIMER_BITS > CYCLE_W) ? TIMER_BITS : CYCLE_W;
  localparam logic [WideW-1:0] TimerMaxWide = WideW'({TIMER_BITS{1'b1}});

  // Clamp a count register into the timer range, zero acts as one
  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [CYCLE_W-1:0] cnt);
    logic [WideW-1:0] w;
    begin
      w = WideW'(cnt);
      if (w == '0) begin
        w = WideW'(1);
      end else if (w > TimerMaxWide) begin
        w = TimerMaxWide;
      end
      sat_load = w[TIMER_BITS-1:0];
    end
  endfunction

  logic [3:0]            phase, phase_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [BYTE_W-1:0]     shift_byte, shift_byte_next;
  logic [TIMER_BITS-1:0] phase_timer, phase_timer_next;
  logic [BYTE_W-1:0]     received_byte, received_byte_next;
  logic                  final_read, final_read_next;
  logic                  scl_drive, scl_drive_next;
  logic                  sda_drive, sda_drive_next;
  logic                  read_mode, read_mode_next;
  logic                  nack_flag, nack_flag_next;

  logic [TIMER_BITS-1:0] low_load, high_load;
  logic                  expired;
  logic [TIMER_BITS-1:0] timer_step;
  logic                  enter_low;
  logic                  done, nack;

  assign low_load   = sat_load(timing.low_cycles);
  assign high_load  = sat_load(timing.high_cycles);
  assign expired    = (phase_timer <= TIMER_BITS'(1));
  assign timer_step = expired ? '0 : phase_timer - TIMER_BITS'(1);

  // Next state for one tick
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    phase_timer_next   = phase_timer;
    received_byte_next = received_byte;
    final_read_next    = final_read;
    scl_drive_next     = scl_drive;
    sda_drive_next     = sda_drive;
    read_mode_next     = read_mode;
    nack_flag_next     = nack_flag;
    enter_low          = 1'b0;
    done               = 1'b0;
    nack               = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (cmd.action == ACT_START) begin
          shift_byte_next = cmd.data_byte;
          read_mode_next  = 1'b0;
          nack_flag_next  = 1'b0;
          bit_count_next  = '0;
          scl_drive_next  = 1'b1;
          sda_drive_next  = 1'b1;
          phase_next      = PH_START_WAIT;
        end else if (cmd.action == ACT_WRITE || cmd.action == ACT_READ) begin
          read_mode_next  = (cmd.action == ACT_READ);
          shift_byte_next = (cmd.action == ACT_READ) ? BYTE_ONES : cmd.data_byte;
          final_read_next = cmd.last_read;
          nack_flag_next  = 1'b0;
          bit_count_next  = '0;
          enter_low       = 1'b1;
        end else if (cmd.action == ACT_STOP) begin
          sda_drive_next = 1'b0;
          scl_drive_next = 1'b1;
          phase_next     = PH_STOP_WAIT;
        end
      end
      PH_START_WAIT: begin
        if (cmd.scl_level) begin
          phase_timer_next = low_load;
          phase_next       = PH_START_SETUP;
        end
      end
      PH_START_SETUP: begin
        phase_timer_next = timer_step;
        if (expired) begin
          sda_drive_next   = 1'b0;
          phase_timer_next = high_load;
          phase_next       = PH_START_HOLD;
        end
      end
      PH_START_HOLD: begin
        phase_timer_next = timer_step;
        if (expired) begin
          enter_low = 1'b1;
        end
      end
      PH_BIT_LOW: begin
        phase_timer_next = timer_step;
        if (expired) begin
          scl_drive_next = 1'b1;
          phase_next     = PH_BIT_WAIT;
        end
      end
      PH_BIT_WAIT: begin
        if (cmd.scl_level) begin
          if (bit_count < 4'd8) begin
            shift_byte_next = {shift_byte[BYTE_W-2:0], cmd.sda_level};
            if (bit_count == 4'd7 && read_mode) begin
              received_byte_next = {shift_byte[BYTE_W-2:0], cmd.sda_level};
            end
          end else if (!read_mode) begin
            nack_flag_next = cmd.sda_level;
          end
          phase_timer_next = high_load;
          phase_next       = PH_BIT_HIGH;
        end
      end
      PH_BIT_HIGH: begin
        phase_timer_next = timer_step;
        if (expired) begin
          scl_drive_next = 1'b0;
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next >= 4'd9) begin
            sda_drive_next   = 1'b1;
            shift_byte_next  = BYTE_ONES;
            phase_timer_next = low_load;
            phase_next       = PH_TAIL;
          end else begin
            enter_low = 1'b1;
          end
        end
      end
      PH_TAIL: begin
        phase_timer_next = timer_step;
        if (expired) begin
          done           = 1'b1;
          nack           = nack_flag;
          nack_flag_next = 1'b0;
          bit_count_next = '0;
          phase_next     = PH_IDLE;
        end
      end
      PH_STOP_WAIT: begin
        if (cmd.scl_level) begin
          phase_timer_next = high_load;
          phase_next       = PH_STOP_HOLD;
        end
      end
      PH_STOP_HOLD: begin
        phase_timer_next = timer_step;
        if (expired) begin
          sda_drive_next   = 1'b1;
          phase_timer_next = low_load;
          phase_next       = PH_STOP_TAIL;
        end
      end
      PH_STOP_TAIL: begin
        phase_timer_next = timer_step;
        if (expired) begin
          done       = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // Open a bit slot: pull SCL low and set up SDA for the slot
    if (enter_low) begin
      scl_drive_next = 1'b0;
      if (bit_count_next < 4'd8) begin
        sda_drive_next = read_mode_next ? 1'b1 : shift_byte_next[BYTE_W-1];
      end else begin
        sda_drive_next = read_mode_next ? final_read_next : 1'b1;
      end
      phase_timer_next = low_load;
      phase_next       = PH_BIT_LOW;
    end
  end

  // Result reflects the state after the tick
  always_comb begin
    result.scl_release = scl_drive_next;
    result.sda_release = sda_drive_next;
    result.busy_res    = (phase_next != PH_IDLE);
    result.done_res    = done;
    result.nack_seen   = nack & done;
    result.read_data   = received_byte_next;
  end

  // Advance the state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      shift_byte    <= BYTE_ONES;
      phase_timer   <= '0;
      received_byte <= BYTE_ZEROS;
      final_read    <= 1'b0;
      scl_drive     <= 1'b1;
      sda_drive     <= 1'b1;
      read_mode     <= 1'b0;
      nack_flag     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      phase_timer   <= phase_timer_next;
      received_byte <= received_byte_next;
      final_read    <= final_read_next;
      scl_drive     <= scl_drive_next;
      sda_drive     <= sda_drive_next;
      read_mode     <= read_mode_next;
      nack_flag     <= nack_flag_next;
    end
  end

  `I2CMS_ASSERT_NOW(a_bit_count_range, clk, rst, 1'b1, bit_count <= 4'd9, "bit count past ack slot")
  `I2CMS_ASSERT_NOW(a_start_hold_lines, clk, rst, phase == PH_START_HOLD, !sda_drive && scl_drive, "start hold lines wrong")
  `I2CMS_ASSERT_NOW(a_nack_with_done, clk, rst, accept && result.nack_seen, result.done_res, "nack without done")
  `I2CMS_ASSERT_NEXT(a_hold_without_tick, clk, rst, !accept, $stable(phase) && $stable(phase_timer), "state moved without tick")

endmodule

[rtl/i2cms_out_buf.sv]
// ----------------------------------------------------------------------------
// i2cms_out_buf
// Two-entry result buffer: an output register plus a skid register, so a new
// tick is taken while a finished result still waits.
// ----------------------------------------------------------------------------
module i2cms_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cms_pkg::res_t  push_data,
  output logic             push_ready,
  i2cms_stream_if.source   res
);
  import i2cms_pkg::*;

  logic out_valid;
  logic skid_valid;
  res_t out_data;
  res_t skid_data;
  logic pop;

  assign pop         = out_valid && res.ready;
  assign push_ready  = !skid_valid;
  assign res.valid   = out_valid;
  assign res.payload = out_data;

  // Track occupancy of both entries
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payloads alongside the valid bits
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[rtl/i2c_master_byte_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_unit
// I2C master that steps through start, byte and stop sequences, one tick per
// command request.
// ----------------------------------------------------------------------------
// Every request on cmd is one bus tick and yields exactly one request on res,
// registered in the output buffer. A tick is taken every cycle unless the
// skid is full: the sequencer state register updates once per tick, and a
// two-entry output buffer keeps cmd ready while up to one finished result
// waits on res. Bus timing is counted in ticks, not clock cycles: each SCL
// low and high phase lasts the count in the cfg registers (0 acts as 1), and
// clock stretching holds the sequence for as many ticks as SCL reads low.
// Write cfg only while no command is running and res is drained.
module i2c_master_byte_sequencer_unit #(
  parameter int TIMER_BITS = i2cms_pkg::TIMER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  i2cms_stream_if.sink   cmd,
  i2cms_stream_if.source res,
  i2cms_stream_if.sink   cfg
);
  import i2cms_pkg::*;

  timing_cfg_t timing;
  res_t        result;
  logic        accept;
  logic        push_ready;

  assign cmd.ready = push_ready;
  assign accept    = cmd.valid && push_ready;

  // Timing registers
  i2cms_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .timing (timing)
  );

  // Bus sequencer
  i2cms_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd.payload),
    .timing (timing),
    .result (result)
  );

  // Result buffer
  i2cms_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (push_ready),
    .res        (res)
  );

endmodule
